@@ rtl/core/frp_pkg.sv @@
package frp_pkg;

   typedef enum logic [1:0] {
      PH_STATUS = 2'd0,
      PH_TEXT   = 2'd1,
      PH_EXPLF  = 2'd2
   } phase_type;

   localparam logic [1:0] KIND_TEXT = 2'd0;
   localparam logic [1:0] KIND_MORE = 2'd1;
   localparam logic [1:0] KIND_DONE = 2'd2;
   localparam logic [1:0] KIND_ERR  = 2'd3;

   localparam logic [2:0] ERR_NONE      = 3'd0;
   localparam logic [2:0] ERR_MALFORMED = 3'd1;
   localparam logic [2:0] ERR_NO_LF     = 3'd2;
   localparam logic [2:0] ERR_STATUS    = 3'd3;
   localparam logic [2:0] ERR_MISMATCH  = 3'd4;

   localparam int PFX_LEN = 23;
   localparam logic [4:0] MP_NUM_START  = 5'd23;
   localparam logic [4:0] MP_NUM_DIGITS = 5'd24;
   localparam logic [4:0] MP_DONE       = 5'd25;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // One result as it moves from the parser to the output stage.
   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  text_byte;
      logic [9:0]  reply_status;
      logic [2:0]  error_code;
      logic        passive_seen;
      logic [31:0] passive_ip;
      logic [15:0] pasv_port;
   } result_type;

   function automatic logic [7:0] prefix_char(input logic [4:0] pos);
      logic [7:0] c;
      case (pos)
         5'd0: c = "E";   5'd1: c = "n";   5'd2: c = "t";   5'd3: c = "e";
         5'd4: c = "r";   5'd5: c = "i";   5'd6: c = "n";   5'd7: c = "g";
         5'd8: c = " ";   5'd9: c = "P";   5'd10: c = "a";  5'd11: c = "s";
         5'd12: c = "s";  5'd13: c = "i";  5'd14: c = "v";  5'd15: c = "e";
         5'd16: c = " ";  5'd17: c = "M";  5'd18: c = "o";  5'd19: c = "d";
         5'd20: c = "e";  5'd21: c = " ";  5'd22: c = "(";
         default: c = 8'd0;
      endcase
      return c;
   endfunction

endpackage

@@ rtl/core/frp_parser.sv @@
module frp_parser import frp_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   input  logic [7:0] in_byte,
   output logic       res_valid,
   output result_type res_data
);

   phase_type   phase_ff, phase_in;
   logic [2:0]  dcnt_ff, dcnt_in;
   logic [9:0]  dval_ff, dval_in;
   logic        more_ff, more_in;
   logic        first_ff, first_in;
   logic [9:0]  held_ff, held_in;
   logic [4:0]  mpos_ff, mpos_in;
   logic [2:0]  nidx_ff, nidx_in;
   logic [7:0]  nacc_ff, nacc_in;
   logic        alive_ff, alive_in;
   logic [47:0] pend_ff, pend_in;
   logic [47:0] latch_ff, latch_in;
   logic        lvalid_ff, lvalid_in;

   logic        is_dig;
   logic [3:0]  dig;
   logic [7:0]  nacc_x10;
   logic [47:0] pend_store;
   logic [5:0]  shamt;
   logic        do_match;

   assign is_dig = (in_byte >= "0") && (in_byte <= "9");
   assign dig = in_byte[3:0];
   assign nacc_x10 = {nacc_ff[4:0], 3'b000} + {nacc_ff[6:0], 1'b0};
   assign shamt = {3'(3'd5 - nidx_ff), 3'b000};
   assign pend_store = (pend_ff & ~(48'hFF << shamt)) | ({40'd0, nacc_ff} << shamt);

   always_comb begin
      phase_in = phase_ff; dcnt_in = dcnt_ff; dval_in = dval_ff;
      more_in = more_ff; first_in = first_ff; held_in = held_ff;
      mpos_in = mpos_ff; nidx_in = nidx_ff; nacc_in = nacc_ff;
      alive_in = alive_ff; pend_in = pend_ff; latch_in = latch_ff;
      lvalid_in = lvalid_ff;
      res_valid = 1'b0;
      res_data.kind = KIND_TEXT;
      res_data.text_byte = 8'd0;
      res_data.reply_status = 10'd0;
      res_data.error_code = ERR_NONE;
      do_match = 1'b0;
      if (in_valid) begin
         case (phase_ff)
            PH_STATUS: begin
               if (is_dig) begin
                  if (dcnt_ff < 3'd3)
                     dval_in = 10'({dval_ff, 3'b000} + {dval_ff, 1'b0} + {6'd0, dig});
                  if (dcnt_ff < 3'd4) dcnt_in = dcnt_ff + 3'd1;
               end else if (in_byte == " " || in_byte == "-") begin
                  more_in = (in_byte == "-");
                  phase_in = PH_TEXT;
               end else if (in_byte == 8'h0D) begin
                  more_in = 1'b1;
                  phase_in = PH_EXPLF;
               end else if (dcnt_ff != 3'd0) begin
                  res_valid = 1'b1;
                  res_data.kind = KIND_ERR;
                  res_data.error_code = ERR_MALFORMED;
               end else begin
                  phase_in = PH_TEXT;
                  do_match = 1'b1;
                  res_valid = 1'b1;
                  res_data.text_byte = in_byte;
               end
            end
            PH_TEXT: begin
               if (in_byte == 8'h0D) phase_in = PH_EXPLF;
               else begin
                  do_match = 1'b1;
                  res_valid = 1'b1;
                  res_data.text_byte = in_byte;
               end
            end
            default: begin
               res_valid = 1'b1;
               if (in_byte != 8'h0A) begin
                  res_data.kind = KIND_ERR;
                  res_data.error_code = ERR_NO_LF;
               end else if (first_ff) begin
                  if (dcnt_ff != 3'd3) begin
                     res_data.kind = KIND_ERR;
                     res_data.error_code = ERR_STATUS;
                  end else begin
                     held_in = dval_ff;
                     if (alive_ff && mpos_ff == MP_DONE) begin
                        latch_in = pend_ff;
                        lvalid_in = 1'b1;
                     end
                     first_in = !more_ff;
                     res_data.kind = more_ff ? KIND_MORE : KIND_DONE;
                     res_data.reply_status = dval_ff;
                  end
               end else if (dcnt_ff != 3'd0 &&
                            (dcnt_ff > 3'd3 || dval_ff != held_ff)) begin
                  res_data.kind = KIND_ERR;
                  res_data.error_code = ERR_MISMATCH;
               end else begin
                  if (dcnt_ff == 3'd0) more_in = 1'b1;
                  if (dcnt_ff == 3'd0 || more_ff) res_data.kind = KIND_MORE;
                  else begin
                     res_data.kind = KIND_DONE;
                     first_in = 1'b1;
                  end
                  res_data.reply_status = held_ff;
               end
               phase_in = PH_STATUS; dcnt_in = 3'd0; dval_in = 10'd0;
               mpos_in = 5'd0; nidx_in = 3'd0; nacc_in = 8'd0;
               alive_in = 1'b1; pend_in = 48'd0;
            end
         endcase
         if (do_match && first_ff && alive_ff && mpos_ff < MP_DONE) begin
            if (mpos_ff < 5'(PFX_LEN)) begin
               if (in_byte == prefix_char(mpos_ff)) mpos_in = mpos_ff + 5'd1;
               else alive_in = 1'b0;
            end else if (mpos_ff == MP_NUM_START) begin
               if (is_dig) begin
                  nacc_in = {4'd0, dig};
                  mpos_in = MP_NUM_DIGITS;
               end else alive_in = 1'b0;
            end else if (is_dig) begin
               nacc_in = nacc_x10 + {4'd0, dig};
            end else if (in_byte == "," && nidx_ff < 3'd5) begin
               pend_in = pend_store;
               nidx_in = nidx_ff + 3'd1;
               mpos_in = MP_NUM_START;
            end else if (in_byte == ")" && nidx_ff == 3'd5) begin
               pend_in = pend_store;
               mpos_in = MP_DONE;
            end else alive_in = 1'b0;
         end
         // Any error clears line, reply and match state.
         if (res_valid && res_data.kind == KIND_ERR) begin
            phase_in = PH_STATUS; dcnt_in = 3'd0; dval_in = 10'd0;
            mpos_in = 5'd0; nidx_in = 3'd0; nacc_in = 8'd0;
            alive_in = 1'b1; pend_in = 48'd0;
            more_in = 1'b0; first_in = 1'b1; held_in = 10'd0;
         end
      end
      res_data.passive_seen = lvalid_in;
      res_data.passive_ip = latch_in[47:16];
      res_data.pasv_port = latch_in[15:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_STATUS; dcnt_ff <= 3'd0; dval_ff <= 10'd0;
         more_ff <= 1'b0; first_ff <= 1'b1; held_ff <= 10'd0;
         mpos_ff <= 5'd0; nidx_ff <= 3'd0; nacc_ff <= 8'd0;
         alive_ff <= 1'b1; pend_ff <= 48'd0; latch_ff <= 48'd0;
         lvalid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in; dcnt_ff <= dcnt_in; dval_ff <= dval_in;
         more_ff <= more_in; first_ff <= first_in; held_ff <= held_in;
         mpos_ff <= mpos_in; nidx_ff <= nidx_in; nacc_ff <= nacc_in;
         alive_ff <= alive_in; pend_ff <= pend_in; latch_ff <= latch_in;
         lvalid_ff <= lvalid_in;
      end
   end

endmodule

@@ rtl/core/frp_queue.sv @@
module frp_queue import frp_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  result_type push_data,
   output logic       space,
   output logic       out_valid,
   input  logic       out_ready,
   output result_type out_data
);

   result_type slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wptr_ff, rptr_ff;
   logic [QUEUE_CNT_W-1:0] count_ff;
   logic       pop;

   assign space = (count_ff < QUEUE_CNT_W'(QUEUE_DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_data = slot_ff[rptr_ff];
   assign pop = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (push) slot_ff[wptr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0; rptr_ff <= '0; count_ff <= '0;
      end else begin
         if (push) begin
            wptr_ff <= (wptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 :
                       wptr_ff + QUEUE_PTR_W'(1);
         end
         if (pop) begin
            rptr_ff <= (rptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 :
                       rptr_ff + QUEUE_PTR_W'(1);
         end
         count_ff <= count_ff + QUEUE_CNT_W'(push) - QUEUE_CNT_W'(pop);
      end
   end

endmodule

@@ rtl/core/ftp_reply_parser.sv @@
// A result is written into the result queue as its byte is accepted.
// Throughput: one byte per cycle while the queue has space (req_ready).
// A two-entry result queue lets req_ keep flowing while rsp_ stalls briefly.
// Synchronous active-high reset returns the parser to the status field of a
// new reply, empties the queue and clears the latched passive address.
module ftp_reply_parser import frp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_byte_in,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_kind,
   output logic [7:0]  rsp_text_byte,
   output logic [9:0]  rsp_reply_status,
   output logic [2:0]  rsp_error_code,
   output logic        rsp_passive_seen,
   output logic [31:0] rsp_passive_ip,
   output logic [15:0] rsp_pasv_port
);

   logic       space, res_valid;
   result_type res_data, q_data;

   assign req_ready = space;

   frp_parser u_parser (
      .clock, .reset,
      .in_valid(req_valid && req_ready),
      .in_byte(req_byte_in),
      .res_valid, .res_data
   );

   frp_queue u_queue (
      .clock, .reset,
      .push(res_valid), .push_data(res_data), .space,
      .out_valid(rsp_valid), .out_ready(rsp_ready), .out_data(q_data)
   );

   assign rsp_kind = q_data.kind;
   assign rsp_text_byte = q_data.text_byte;
   assign rsp_reply_status = q_data.reply_status;
   assign rsp_error_code = q_data.error_code;
   assign rsp_passive_seen = q_data.passive_seen;
   assign rsp_passive_ip = q_data.passive_ip;
   assign rsp_pasv_port = q_data.pasv_port;

endmodule

@@ rtl/core/frp_checker.sv @@
module frp_checker import frp_pkg::*; (
   input logic       clock,
   input logic       reset,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] rsp_kind,
   input logic [7:0] rsp_text_byte,
   input logic [9:0] rsp_reply_status,
   input logic [2:0] rsp_error_code
);

   a_err_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_kind == KIND_ERR) == (rsp_error_code != ERR_NONE)))
      else $error("error code does not match kind");

   a_text_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != KIND_TEXT |-> rsp_text_byte == 8'd0)
      else $error("text byte set on non-text transaction");

   a_status_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_TEXT || rsp_kind == KIND_ERR)
      |-> rsp_reply_status == 10'd0)
      else $error("status set outside a line end");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind))
      else $error("stalled transaction changed");

   // The input only stalls when the result queue is full.
   a_full_valid: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("input stalled with no pending result");

endmodule

bind ftp_reply_parser frp_checker u_frp_checker (
   .clock, .reset, .req_ready, .rsp_valid, .rsp_ready,
   .rsp_kind, .rsp_text_byte, .rsp_reply_status, .rsp_error_code
);
